// ===== sv/i2cm_pkg.sv =====
// i2cm_pkg: types, codes and constants shared by the i2c master byte engine
// no dependencies; imported by every module of the block

package i2cm_pkg;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  // bit positions inside out_tdata
  localparam int unsigned OUT_BIT_SCL   = 0;
  localparam int unsigned OUT_BIT_SDA   = 1;
  localparam int unsigned OUT_BIT_DRV   = 2;
  localparam int unsigned OUT_BIT_BUSY  = 3;
  localparam int unsigned OUT_BIT_DONE  = 4;
  localparam int unsigned OUT_BIT_NACK  = 13;

  // bus phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_S_SETUP = 4'd1,
    PH_S_HOLD  = 4'd2,
    PH_P_LOW   = 4'd3,
    PH_P_HIGH  = 4'd4,
    PH_P_FREE  = 4'd5,
    PH_W_HOLD  = 4'd6,
    PH_W_SET   = 4'd7,
    PH_W_HIGH  = 4'd8,
    PH_R_LOW   = 4'd9,
    PH_R_HIGH  = 4'd10
  } phase_t;

  // command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // timing register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_HOLD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SETUP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MINUS_HOLD = 3'd6;

  // bit counter limits
  localparam logic [3:0] LAST_BIT  = 4'd7;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // phase steps that can chain in one tick after the bit-loop skip
  localparam int unsigned ADV_STEPS = 5;

  typedef struct packed {
    logic [7:0] start_low;
    logic [7:0] clock_low;
    logic [7:0] clock_high;
    logic [7:0] data_hold;
    logic [7:0] stop_setup;
    logic [7:0] idle_gap;
    logic [7:0] low_minus_hold;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       sda_sample;
  } tick_in_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] kind;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    logic       ack_bit;
    logic       scl;
    logic       sda;
    logic       sda_dir;
    logic       nack;
    logic [7:0] read_hold;
  } eng_st_t;

  localparam cfg_t CFG_RESET = '{
    start_low:      8'd40,
    clock_low:      8'd47,
    clock_high:     8'd40,
    data_hold:      8'd1,
    stop_setup:     8'd40,
    idle_gap:       8'd47,
    low_minus_hold: 8'd47
  };

  localparam eng_st_t ENG_RESET = '{
    phase:     PH_IDLE,
    kind:      CMD_NONE,
    bit_idx:   4'd0,
    shift:     8'd0,
    ack_bit:   1'b0,
    scl:       1'b1,
    sda:       1'b1,
    sda_dir:   1'b1,
    nack:      1'b0,
    read_hold: 8'd0
  };

  // clamp a timing count to what a dw-bit counter holds
  function automatic logic [15:0] sat_count(input logic [7:0] t, input int unsigned dw);
    logic [31:0] lim;
    lim = (32'd1 << dw) - 32'd1;
    if (32'(t) > lim) return lim[15:0];
    return 16'(t);
  endfunction

endpackage

// ===== sv/i2cm_cfg_regs.sv =====
// i2cm_cfg_regs: the seven timing registers of the i2c master byte engine
// depends on i2cm_pkg

module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        CFG_START_LOW:      cfg_nxt.start_low      = wr_data;
        CFG_CLOCK_LOW:      cfg_nxt.clock_low      = wr_data;
        CFG_CLOCK_HIGH:     cfg_nxt.clock_high     = wr_data;
        CFG_DATA_HOLD:      cfg_nxt.data_hold      = wr_data;
        CFG_STOP_SETUP:     cfg_nxt.stop_setup     = wr_data;
        CFG_IDLE_GAP:       cfg_nxt.idle_gap       = wr_data;
        CFG_LOW_MINUS_HOLD: cfg_nxt.low_minus_hold = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== sv/i2cm_adv.sv =====
// i2cm_adv: one phase transition of the bus sequencer, taken when the count is spent
// depends on i2cm_pkg

module i2cm_adv
  import i2cm_pkg::*;
#(
  parameter int unsigned DW = 8
) (
  input  eng_st_t       st_i,
  input  logic [DW-1:0] dly_i,
  input  cfg_t          cfg_i,
  input  logic          s_i,
  output eng_st_t       st_o,
  output logic [DW-1:0] dly_o,
  output logic          done_o
);

  logic [3:0] idx_inc;
  logic [7:0] shift_in;
  logic [2:0] bit_sel;

  assign idx_inc  = st_i.bit_idx + 4'd1;
  assign shift_in = {st_i.shift[6:0], s_i};
  assign bit_sel  = 3'd7 - st_i.bit_idx[2:0];

  always_comb begin
    st_o   = st_i;
    dly_o  = dly_i;
    done_o = 1'b0;
    if (st_i.phase != PH_IDLE && dly_i == '0) begin
      case (st_i.phase)
        PH_S_SETUP: begin
          st_o.scl   = 1'b1;
          st_o.sda   = 1'b0;
          st_o.phase = PH_S_HOLD;
          dly_o      = DW'(sat_count(cfg_i.start_low, DW));
        end
        PH_S_HOLD: begin
          st_o.scl   = 1'b0;
          st_o.phase = PH_IDLE;
          dly_o      = '0;
          done_o     = 1'b1;
        end
        PH_P_LOW: begin
          st_o.scl   = 1'b1;
          st_o.phase = PH_P_HIGH;
          dly_o      = DW'(sat_count(cfg_i.stop_setup, DW));
        end
        PH_P_HIGH: begin
          st_o.sda   = 1'b1;
          st_o.phase = PH_P_FREE;
          dly_o      = DW'(sat_count(cfg_i.idle_gap, DW));
        end
        PH_P_FREE: begin
          st_o.phase = PH_IDLE;
          dly_o      = '0;
          done_o     = 1'b1;
        end
        PH_W_HOLD: begin
          // data bit for a write, ack/nack for the tail of a read
          if (st_i.kind == CMD_WRITE) begin
            st_o.sda = st_i.shift[bit_sel];
          end else begin
            st_o.sda = !st_i.ack_bit;
          end
          st_o.phase = PH_W_SET;
          dly_o      = DW'(sat_count(cfg_i.low_minus_hold, DW));
        end
        PH_W_SET: begin
          st_o.scl   = 1'b1;
          st_o.phase = PH_W_HIGH;
          dly_o      = DW'(sat_count(cfg_i.clock_high, DW));
        end
        PH_W_HIGH: begin
          st_o.scl = 1'b0;
          if (st_i.kind == CMD_WRITE) begin
            st_o.bit_idx = idx_inc;
            if (idx_inc < BYTE_BITS) begin
              st_o.phase = PH_W_HOLD;
              dly_o      = DW'(sat_count(cfg_i.data_hold, DW));
            end else begin
              st_o.sda_dir = 1'b0;
              st_o.phase   = PH_R_LOW;
              dly_o        = DW'(sat_count(cfg_i.clock_low, DW));
            end
          end else begin
            st_o.phase = PH_IDLE;
            dly_o      = '0;
            done_o     = 1'b1;
          end
        end
        PH_R_LOW: begin
          st_o.scl   = 1'b1;
          st_o.phase = PH_R_HIGH;
          dly_o      = DW'(sat_count(cfg_i.clock_high, DW));
        end
        PH_R_HIGH: begin
          st_o.scl = 1'b0;
          if (st_i.kind == CMD_WRITE) begin
            st_o.nack  = s_i;
            st_o.phase = PH_IDLE;
            dly_o      = '0;
            done_o     = 1'b1;
          end else begin
            st_o.shift   = shift_in;
            st_o.bit_idx = idx_inc;
            if (idx_inc < BYTE_BITS) begin
              st_o.phase = PH_R_LOW;
              dly_o      = DW'(sat_count(cfg_i.clock_low, DW));
            end else begin
              st_o.read_hold = shift_in;
              st_o.sda_dir   = 1'b1;
              st_o.phase     = PH_W_HOLD;
              dly_o          = DW'(sat_count(cfg_i.data_hold, DW));
            end
          end
        end
        default: begin
          st_o.phase = PH_IDLE;
          dly_o      = '0;
        end
      endcase
    end
  end

endmodule

// ===== sv/i2cm_tick.sv =====
// i2cm_tick: everything one tick does to the sequencer state
// depends on i2cm_pkg and i2cm_adv

module i2cm_tick
  import i2cm_pkg::*;
#(
  parameter int unsigned DW = 8
) (
  input  eng_st_t       st_i,
  input  logic [DW-1:0] dly_i,
  input  cfg_t          cfg_i,
  input  tick_in_t      in_i,
  output eng_st_t       st_o,
  output logic [DW-1:0] dly_o,
  output logic          done_o
);

  eng_st_t       pre_st;
  logic [DW-1:0] pre_dly;
  eng_st_t       ff_st;
  logic          wr_skip;
  logic          rd_skip;
  logic [2:0]    rd_left;
  logic [15:0]   rd_ext;

  eng_st_t             chain_st  [ADV_STEPS+1];
  logic [DW-1:0]       chain_dly [ADV_STEPS+1];
  logic [ADV_STEPS-1:0] chain_done;

  // command launch from idle, otherwise count down
  always_comb begin
    pre_st  = st_i;
    pre_dly = dly_i;
    if (st_i.phase == PH_IDLE) begin
      case (in_i.cmd)
        CMD_START: begin
          pre_st.kind    = CMD_START;
          pre_st.bit_idx = '0;
          pre_st.sda_dir = 1'b1;
          pre_st.sda     = 1'b1;
          pre_st.phase   = PH_S_SETUP;
          pre_dly        = DW'(sat_count(cfg_i.data_hold, DW));
        end
        CMD_STOP: begin
          pre_st.kind    = CMD_STOP;
          pre_st.bit_idx = '0;
          pre_st.sda_dir = 1'b1;
          pre_st.sda     = 1'b0;
          pre_st.phase   = PH_P_LOW;
          pre_dly        = DW'(sat_count(cfg_i.low_minus_hold, DW));
        end
        CMD_WRITE: begin
          pre_st.kind    = CMD_WRITE;
          pre_st.bit_idx = '0;
          pre_st.sda_dir = 1'b1;
          pre_st.shift   = in_i.write_data;
          pre_st.phase   = PH_W_HOLD;
          pre_dly        = DW'(sat_count(cfg_i.data_hold, DW));
        end
        CMD_READ: begin
          pre_st.kind    = CMD_READ;
          pre_st.bit_idx = '0;
          pre_st.sda_dir = 1'b0;
          pre_st.shift   = '0;
          pre_st.ack_bit = in_i.ack_to_send;
          pre_st.phase   = PH_R_LOW;
          pre_dly        = DW'(sat_count(cfg_i.clock_low, DW));
        end
        default: pre_st = st_i;
      endcase
    end else if (dly_i != '0) begin
      pre_dly = dly_i - DW'(1);
    end
  end

  // with every count of the bit loop at zero, jump to the last bit in one go
  assign wr_skip = pre_dly == '0 && pre_st.kind == CMD_WRITE &&
                   (pre_st.phase == PH_W_HOLD || pre_st.phase == PH_W_SET ||
                    pre_st.phase == PH_W_HIGH) &&
                   cfg_i.data_hold == '0 && cfg_i.low_minus_hold == '0 &&
                   cfg_i.clock_high == '0;
  assign rd_skip = pre_dly == '0 && pre_st.kind == CMD_READ && !pre_st.bit_idx[3] &&
                   (pre_st.phase == PH_R_LOW || pre_st.phase == PH_R_HIGH) &&
                   cfg_i.clock_low == '0 && cfg_i.clock_high == '0;
  assign rd_left = 3'd7 - pre_st.bit_idx[2:0];
  assign rd_ext  = {pre_st.shift, {8{in_i.sda_sample}}} << rd_left;

  always_comb begin
    ff_st = pre_st;
    if (wr_skip) begin
      ff_st.phase   = PH_W_HOLD;
      ff_st.bit_idx = LAST_BIT;
    end else if (rd_skip) begin
      ff_st.phase   = PH_R_LOW;
      ff_st.bit_idx = LAST_BIT;
      ff_st.shift   = rd_ext[15:8];
    end
  end

  assign chain_st[0]  = ff_st;
  assign chain_dly[0] = pre_dly;

  for (genvar g = 0; g < ADV_STEPS; g++) begin : g_adv
    i2cm_adv #(.DW(DW)) u_adv (
      .st_i   (chain_st[g]),
      .dly_i  (chain_dly[g]),
      .cfg_i  (cfg_i),
      .s_i    (in_i.sda_sample),
      .st_o   (chain_st[g+1]),
      .dly_o  (chain_dly[g+1]),
      .done_o (chain_done[g])
    );
  end

  assign st_o   = chain_st[ADV_STEPS];
  assign dly_o  = chain_dly[ADV_STEPS];
  assign done_o = |chain_done;

endmodule

// ===== sv/i2c_master_byte_engine_top.sv =====
// i2c_master_byte_engine_top: tick-driven i2c master, one input item per bus tick
// depends on i2cm_pkg, i2cm_cfg_regs, i2cm_tick and i2cm_adv
//
// usage
//   every item on the in_ stream is one bus tick (one microsecond) and carries
//   a command, a write byte, the ack to send after a read and the sampled sda
//   level; a command is taken only while the sequencer is idle
//   every item gives exactly one item on the out_ stream with the pin levels,
//   busy, a done pulse, the last read byte and the last write's nack flag
//   timing registers are to be written over the cfg_ channel only while no command
//   runs, which the block does not enforce; cfg_ready is always high
// pipeline and throughput
//   an accepted item waits in the input register; one item per cycle is
//   sustained while out_tready is high, set by the single pass through the
//   tick logic between the input register and the result register
// reset
//   synchronous, active low: both stream stages empty, timing registers back
//   to their defaults, bus idle with scl and sda high and sda driven
// stall
//   while out_tready is low the result item holds, one more input item is
//   taken into the input register, then in_tready drops until the result moves

module i2c_master_byte_engine_top
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] cmd, [10:3] write_data, [11] ack_to_send, [12] sda_sample, [15:13] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_driving, [3] busy_res, [4] done_res,
  // [12:5] read_byte, [13] got_nack, [15:14] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // timing register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // input register stage
  logic     in_vld_r;
  logic     in_vld_nxt;
  tick_in_t in_item_r;

  // sequencer state
  eng_st_t                st_r;
  logic [DELAY_WIDTH-1:0] dly_r;

  // result register stage
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  cfg_t                   cfg;
  eng_st_t                st_nxt;
  logic [DELAY_WIDTH-1:0] dly_nxt;
  logic                   done_now;
  logic                   proc;
  logic                   in_fire;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  assign cfg_ready = 1'b1;

  i2cm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg_o   (cfg)
  );

  // a held tick is processed when the result slot is free or being drained
  assign proc      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc;
  assign in_fire   = in_tvalid && in_tready;

  assign in_vld_nxt  = in_tready ? in_tvalid : in_vld_r;
  assign out_vld_nxt = proc ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  i2cm_tick #(.DW(DELAY_WIDTH)) u_tick (
    .st_i   (st_r),
    .dly_i  (dly_r),
    .cfg_i  (cfg),
    .in_i   (in_item_r),
    .st_o   (st_nxt),
    .dly_o  (dly_nxt),
    .done_o (done_now)
  );

  // pack the result fields, highest bit first
  assign out_data_nxt = {2'b00, st_nxt.nack, st_nxt.read_hold, done_now,
                         st_nxt.phase != PH_IDLE, st_nxt.sda_dir, st_nxt.sda, st_nxt.scl};

  // control and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= ENG_RESET;
      dly_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (proc) begin
        st_r  <= st_nxt;
        dly_r <= dly_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= '{cmd:         in_tdata[2:0],
                     write_data:  in_tdata[10:3],
                     ack_to_send: in_tdata[11],
                     sda_sample:  in_tdata[12]};
    end
    if (proc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/i2cm_checker.sv =====
// i2cm_checker: port-level checks on the i2c master byte engine, bound to the top level
// depends on i2cm_pkg and i2c_master_byte_engine_top

module i2cm_checker
  import i2cm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a done pulse means the sequencer is already idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_BIT_DONE] |-> !out_tdata[OUT_BIT_BUSY])
    else $error("done reported together with busy");

  // an empty result slot never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result slot");

  // after an accepted item has passed the input register, the result slot is occupied
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("accepted item produced no result");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
